// File: hdl/ctc_pkg.sv
// Shared types, constants and a helper function of the CTC timer.
`default_nettype none

package ctc_pkg;

    localparam int COUNT_BITS    = 8;
    localparam int POST_BITS     = 16;
    localparam int PRESC_BITS    = 10;
    localparam int CFG_ADDR_BITS = 4;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [2:0] PRESC_STOP    = 3'd0;
    localparam logic [2:0] PRESC_DIV1    = 3'd1;
    localparam logic [2:0] PRESC_DIV8    = 3'd2;
    localparam logic [2:0] PRESC_DIV64   = 3'd3;
    localparam logic [2:0] PRESC_DIV256  = 3'd4;
    localparam logic [2:0] PRESC_DIV1024 = 3'd5;

    typedef enum logic [1:0] {
        REG_PRESCALE = 2'd0,
        REG_COMPARE  = 2'd1,
        REG_POST_N   = 2'd2,
        REG_IRQ_EN   = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [2:0]  prescale_select;
        logic [7:0]  compare_value;
        logic [15:0] matches_per_callback;
        logic        match_irq_enable;
    } ctc_cfg_t;

    typedef struct packed {
        logic [7:0] timer_count;
        logic       match_flag;
        logic       match_pulse;
        logic       callback_event;
    } ctc_result_t;

    typedef struct packed {
        logic                  running;
        logic [PRESC_BITS-1:0] mask;
    } presc_t;

    function automatic presc_t presc_decode(input logic [2:0] sel);
        presc_t p;
        p.running = 1'b1;
        unique case (sel)
            PRESC_DIV1:    p.mask = PRESC_BITS'(0);
            PRESC_DIV8:    p.mask = PRESC_BITS'(7);
            PRESC_DIV64:   p.mask = PRESC_BITS'(63);
            PRESC_DIV256:  p.mask = PRESC_BITS'(255);
            PRESC_DIV1024: p.mask = '1;
            default:
            begin
                p.running = 1'b0;
                p.mask    = '0;
            end
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// File: hdl/ctc_in_if.sv
// Input channel: one input clock word per handshake.
`default_nettype none

interface ctc_in_if;
    logic valid;
    logic ready;
    logic clock_enable;
    logic clear_match_flag;

    modport source (output valid, output clock_enable, output clear_match_flag, input ready);
    modport sink (input valid, input clock_enable, input clear_match_flag, output ready);
endinterface

`default_nettype wire

// File: hdl/ctc_out_if.sv
// Output channel: one timer status word per handshake.
`default_nettype none

interface ctc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] timer_count;
    logic       match_flag;
    logic       match_pulse;
    logic       callback_event;

    modport source (
        output valid, output timer_count, output match_flag,
        output match_pulse, output callback_event, input ready
    );
    modport sink (
        input valid, input timer_count, input match_flag,
        input match_pulse, input callback_event, output ready
    );
endinterface

`default_nettype wire

// File: hdl/ctc_core.sv
// Prescaler, clear-on-compare counter, sticky flag and match postscaler.
`default_nettype none

module ctc_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ctc_pkg::ctc_cfg_t    cfg,
    input  wire                  accept,
    input  wire                  clock_enable,
    input  wire                  clear_match_flag,
    output ctc_pkg::ctc_result_t result
);
    import ctc_pkg::*;

    localparam logic [31:0] POST_MAX = 32'((64'd1 << POST_BITS) - 64'd1);

    logic [PRESC_BITS-1:0] presc_reg, presc_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  flag_reg, flag_next;
    logic [POST_BITS-1:0]  post_reg, post_next;

    presc_t                p;
    logic                  tick;
    logic                  match;
    logic                  cb;
    logic [31:0]           n_wide;
    logic [POST_BITS-1:0]  n_post;

    always_comb
    begin
        p          = presc_decode(cfg.prescale_select);
        tick       = 1'b0;
        match      = 1'b0;
        cb         = 1'b0;
        presc_next = presc_reg;
        count_next = count_reg;
        post_next  = post_reg;
        n_wide     = 32'(cfg.matches_per_callback);
        n_post     = (n_wide > POST_MAX) ? POST_BITS'(POST_MAX) : POST_BITS'(n_wide);

        if (clock_enable && p.running)
        begin
            tick       = (presc_reg & p.mask) == p.mask;
            presc_next = presc_reg + PRESC_BITS'(1);
        end

        if (tick)
        begin
            if (count_reg == COUNT_BITS'(cfg.compare_value))
            begin
                count_next = '0;
                match      = 1'b1;
            end
            else
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end

        flag_next = (flag_reg && !clear_match_flag) || match;

        if (match && cfg.match_irq_enable)
        begin
            if (post_reg < n_post)
            begin
                post_next = post_reg + POST_BITS'(1);
            end
            else
            begin
                post_next = POST_BITS'(1);
                cb        = 1'b1;
            end
        end

        result.timer_count    = count_next[7:0];
        result.match_flag     = flag_next;
        result.match_pulse    = match;
        result.callback_event = cb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presc_reg <= '0;
            count_reg <= '0;
            flag_reg  <= 1'b0;
            post_reg  <= POST_BITS'(1);
        end
        else if (accept)
        begin
            presc_reg <= presc_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
            post_reg  <= post_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ctc_skid.sv
// Two-entry result buffer: output register plus skid register.
`default_nettype none

module ctc_skid (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  push,
    input  ctc_pkg::ctc_result_t push_word,
    output logic                 can_push,
    output logic                 pop_valid,
    input  wire                  pop_ready,
    output ctc_pkg::ctc_result_t pop_word
);
    import ctc_pkg::*;

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    ctc_result_t main_reg, main_next;
    ctc_result_t skid_reg, skid_next;
    logic        pop;

    always_comb
    begin
        pop             = main_valid_reg && pop_ready;
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;

        if (pop)
        begin
            main_valid_next = skid_valid_reg;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end

        if (push)
        begin
            if (!main_valid_next)
            begin
                main_valid_next = 1'b1;
                main_next       = push_word;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_next       = push_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign can_push  = !skid_valid_reg;
    assign pop_valid = main_valid_reg;
    assign pop_word  = main_reg;

endmodule

`default_nettype wire

// File: hdl/ctc_timer_with_event_postscaler_unit.sv
// Top level: APB registers, timer core and result buffer.
// An accepted word's status is registered in the result buffer before it is shown.
// Throughput: one word per cycle while ready; timer state steps once per accepted word.
// Input ready is registered and drops only when both result slots are full.
// Reset (rst_n low, asynchronous) clears registers to 0, counters to 0, postscaler to 1.
`default_nettype none

module ctc_timer_with_event_postscaler_unit (
    input  wire                                 clk,
    input  wire                                 rst_n,
    ctc_in_if.sink                              in_ch,
    ctc_out_if.source                           out_ch,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [ctc_pkg::CFG_ADDR_BITS-1:0]   paddr,
    input  wire  [ctc_pkg::CFG_DATA_BITS-1:0]   pwdata,
    output logic [ctc_pkg::CFG_DATA_BITS-1:0]   prdata,
    output logic                                pready
);
    import ctc_pkg::*;

    ctc_cfg_t    cfg_reg;
    ctc_result_t result;
    ctc_result_t out_word;
    logic        accept;
    logic        can_push;
    logic        cfg_write;
    cfg_reg_t    reg_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = cfg_reg_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                REG_PRESCALE: cfg_reg.prescale_select      <= pwdata[2:0];
                REG_COMPARE:  cfg_reg.compare_value        <= pwdata[7:0];
                REG_POST_N:   cfg_reg.matches_per_callback <= pwdata[15:0];
                REG_IRQ_EN:   cfg_reg.match_irq_enable     <= pwdata[0];
                default:      cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_PRESCALE: prdata = CFG_DATA_BITS'(cfg_reg.prescale_select);
            REG_COMPARE:  prdata = CFG_DATA_BITS'(cfg_reg.compare_value);
            REG_POST_N:   prdata = CFG_DATA_BITS'(cfg_reg.matches_per_callback);
            REG_IRQ_EN:   prdata = CFG_DATA_BITS'(cfg_reg.match_irq_enable);
            default:      prdata = '0;
        endcase
    end

    assign in_ch.ready = can_push;
    assign accept      = in_ch.valid && can_push;

    ctc_core u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg_reg),
        .accept           (accept),
        .clock_enable     (in_ch.clock_enable),
        .clear_match_flag (in_ch.clear_match_flag),
        .result           (result)
    );

    ctc_skid u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_word (result),
        .can_push  (can_push),
        .pop_valid (out_ch.valid),
        .pop_ready (out_ch.ready),
        .pop_word  (out_word)
    );

    assign out_ch.timer_count    = out_word.timer_count;
    assign out_ch.match_flag     = out_word.match_flag;
    assign out_ch.match_pulse    = out_word.match_pulse;
    assign out_ch.callback_event = out_word.callback_event;

endmodule

`default_nettype wire

// File: hdl/ctc_chk.sv
// Port-level checker for the CTC timer, bound to the top level.
`default_nettype none

module ctc_chk (
    input wire       clk,
    input wire       rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input wire [7:0] timer_count,
    input wire       match_flag,
    input wire       match_pulse,
    input wire       callback_event
);

    a_pulse_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && match_pulse |-> timer_count == 8'd0)
        else $error("match pulse with nonzero count");

    a_event_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && callback_event |-> match_pulse && match_flag)
        else $error("callback event without match");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && $past(out_valid && !out_ready))
        else $error("input stalled while output side not backed up");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(timer_count)
            && $stable(match_flag))
        else $error("stalled output word changed");

endmodule

bind ctc_timer_with_event_postscaler_unit ctc_chk u_chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .timer_count    (out_ch.timer_count),
    .match_flag     (out_ch.match_flag),
    .match_pulse    (out_ch.match_pulse),
    .callback_event (out_ch.callback_event)
);

`default_nettype wire

// File: verif/tb_ctc_timer_with_event_postscaler_unit.sv
// Testbench for the CTC timer unit: directed and random input words checked against a predictor.
module tb_ctc_timer_with_event_postscaler_unit;
    import ctc_pkg::*;

    localparam logic [2:0] PRESC_UNUSED6 = 3'd6;
    localparam logic [2:0] PRESC_UNUSED7 = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_PRINTED    = 40;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic pready;

    ctc_in_if  in_ch ();
    ctc_out_if out_ch ();

    ctc_timer_with_event_postscaler_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predictor state
    ctc_cfg_t           timer_cfg;
    logic [9:0]         presc_cnt;
    logic [7:0]         timer_cnt;
    logic               flag_q;
    logic [15:0]        post_cnt;
    ctc_result_t        pending_status[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        forever
            @(negedge clk) out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
    endtask

    function automatic ctc_result_t advance_timer(input logic ce, input logic clr);
        logic [9:0]  div_mask;
        logic        running;
        logic        tick;
        logic        hit;
        logic        evt;
        ctc_result_t r;
        running = 1'b1;
        tick    = 1'b0;
        hit     = 1'b0;
        evt     = 1'b0;
        case (timer_cfg.prescale_select)
            PRESC_DIV1:    div_mask = 10'h000;
            PRESC_DIV8:    div_mask = 10'h007;
            PRESC_DIV64:   div_mask = 10'h03F;
            PRESC_DIV256:  div_mask = 10'h0FF;
            PRESC_DIV1024: div_mask = 10'h3FF;
            default:
            begin
                running  = 1'b0;
                div_mask = 10'h000;
            end
        endcase
        if (ce && running)
        begin
            tick      = ((presc_cnt & div_mask) == div_mask);
            presc_cnt = presc_cnt + 10'd1;
        end
        if (tick)
        begin
            if (timer_cnt == timer_cfg.compare_value)
            begin
                timer_cnt = 8'd0;
                hit       = 1'b1;
            end
            else
                timer_cnt = timer_cnt + 8'd1;
        end
        if (clr)
            flag_q = 1'b0;
        if (hit)
            flag_q = 1'b1;
        if (hit && timer_cfg.match_irq_enable)
        begin
            if (post_cnt < timer_cfg.matches_per_callback)
                post_cnt = post_cnt + 16'd1;
            else
            begin
                post_cnt = 16'd1;
                evt      = 1'b1;
            end
        end
        r.timer_count    = timer_cnt;
        r.match_flag     = flag_q;
        r.match_pulse    = hit;
        r.callback_event = evt;
        return r;
    endfunction

    function automatic logic [CFG_DATA_BITS-1:0] reg_value(input cfg_reg_t r);
        case (r)
            REG_PRESCALE: return CFG_DATA_BITS'(timer_cfg.prescale_select);
            REG_COMPARE:  return CFG_DATA_BITS'(timer_cfg.compare_value);
            REG_POST_N:   return CFG_DATA_BITS'(timer_cfg.matches_per_callback);
            default:      return CFG_DATA_BITS'(timer_cfg.match_irq_enable);
        endcase
    endfunction

    // Status word checker and predictor feed
    always @(posedge clk)
    begin : check_status
        ctc_result_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_status.size() == 0)
                    report_mismatch("unexpected status word", int'(out_ch.timer_count), 0);
                else
                begin
                    want = pending_status.pop_front();
                    if (out_ch.timer_count !== want.timer_count)
                        report_mismatch("timer_count", int'(out_ch.timer_count),
                                        int'(want.timer_count));
                    if (out_ch.match_flag !== want.match_flag)
                        report_mismatch("match_flag", int'(out_ch.match_flag),
                                        int'(want.match_flag));
                    if (out_ch.match_pulse !== want.match_pulse)
                        report_mismatch("match_pulse", int'(out_ch.match_pulse),
                                        int'(want.match_pulse));
                    if (out_ch.callback_event !== want.callback_event)
                        report_mismatch("callback_event", int'(out_ch.callback_event),
                                        int'(want.callback_event));
                end
            end
            if (in_ch.valid && in_ch.ready)
                pending_status.push_back(advance_timer(in_ch.clock_enable,
                                                       in_ch.clear_match_flag));
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (psel && penable))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_word(input logic ce, input logic clr);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
            @(negedge clk) in_ch.valid <= 1'b0;
        @(negedge clk);
        in_ch.valid            <= 1'b1;
        in_ch.clock_enable     <= ce;
        in_ch.clear_match_flag <= clr;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    task automatic wait_drained();
        @(negedge clk) in_ch.valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_reg(input cfg_reg_t r, input logic [CFG_DATA_BITS-1:0] value);
        wait_drained();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'({r, 2'b00});
        pwdata  <= value;
        @(negedge clk) penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        case (r)
            REG_PRESCALE: timer_cfg.prescale_select      = value[2:0];
            REG_COMPARE:  timer_cfg.compare_value        = value[7:0];
            REG_POST_N:   timer_cfg.matches_per_callback = value[15:0];
            default:      timer_cfg.match_irq_enable     = value[0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_registers();
        cfg_reg_t r;
        for (int i = 0; i < 4; i++)
        begin
            r = cfg_reg_t'(i);
            @(negedge clk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= CFG_ADDR_BITS'({r, 2'b00});
            @(negedge clk) penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            if (prdata !== reg_value(r))
                report_mismatch(r.name(), prdata, reg_value(r));
            @(negedge clk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    task automatic test_reset_values();
        check_registers();
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b1);
        send_word(1'b0, 1'b0);
    endtask

    task automatic test_register_readback();
        set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_DIV1024));
        set_reg(REG_COMPARE, 32'd255);
        set_reg(REG_POST_N, 32'd65535);
        set_reg(REG_IRQ_EN, 32'd1);
        check_registers();
    endtask

    // compare of zero: every tick matches; N of 0 and 1 give an event per match
    task automatic test_compare_zero();
        set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_DIV1));
        set_reg(REG_COMPARE, 32'd0);
        set_reg(REG_POST_N, 32'd0);
        set_reg(REG_IRQ_EN, 32'd1);
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b0);
        send_word(1'b1, 1'b1);
        set_reg(REG_POST_N, 32'd1);
        send_word(1'b1, 1'b0);
        send_word(1'b0, 1'b1);
    endtask

    task automatic test_postscaler_period();
        set_reg(REG_COMPARE, 32'd1);
        set_reg(REG_POST_N, 32'd3);
        repeat (6) send_word(1'b1, 1'b0);
        set_reg(REG_IRQ_EN, 32'd0);
        repeat (2) send_word(1'b1, 1'b0);
        set_reg(REG_IRQ_EN, 32'd1);
        repeat (2) send_word(1'b1, 1'b0);
    endtask

    task automatic test_unused_prescale_codes();
        set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_UNUSED6));
        send_word(1'b1, 1'b0);
        send_word(1'b1, 1'b1);
        set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_UNUSED7));
        send_word(1'b1, 1'b0);
    endtask

    task automatic randomize_config();
        int pick;
        pick = $urandom_range(99);
        if (pick < 45)      set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_DIV1));
        else if (pick < 70) set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_DIV8));
        else if (pick < 80) set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_DIV64));
        else if (pick < 86) set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_DIV256));
        else if (pick < 90) set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_DIV1024));
        else if (pick < 95) set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_STOP));
        else if (pick < 98) set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_UNUSED6));
        else                set_reg(REG_PRESCALE, CFG_DATA_BITS'(PRESC_UNUSED7));
        pick = $urandom_range(99);
        if (pick < 50)      set_reg(REG_COMPARE, $urandom_range(7));
        else if (pick < 80) set_reg(REG_COMPARE, $urandom_range(40));
        else if (pick < 90) set_reg(REG_COMPARE, 32'd0);
        else                set_reg(REG_COMPARE, 32'd255);
        pick = $urandom_range(99);
        if (pick < 40)      set_reg(REG_POST_N, $urandom_range(4));
        else if (pick < 70) set_reg(REG_POST_N, $urandom_range(20, 5));
        else if (pick < 80) set_reg(REG_POST_N, 32'd0);
        else if (pick < 90) set_reg(REG_POST_N, 32'd1);
        else                set_reg(REG_POST_N, 32'd65535);
        set_reg(REG_IRQ_EN, ($urandom_range(99) < 75) ? 32'd1 : 32'd0);
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 79; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 79; end
                default: begin sender_idle_pct = 21; receiver_stall_pct = 21; end
            endcase
            for (int blk = 0; blk < 5; blk++)
            begin
                randomize_config();
                repeat (52)
                begin
                    send_word($urandom_range(99) < 85, $urandom_range(99) < 12);
                    if ($urandom_range(199) == 0)
                        wait_drained();
                end
            end
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        psel                   = 1'b0;
        penable                = 1'b0;
        pwrite                 = 1'b0;
        paddr                  = '0;
        pwdata                 = '0;
        in_ch.valid            = 1'b0;
        in_ch.clock_enable     = 1'b0;
        in_ch.clear_match_flag = 1'b0;
        timer_cfg              = '0;
        presc_cnt              = '0;
        timer_cnt              = '0;
        flag_q                 = 1'b0;
        post_cnt               = 16'd1;
        repeat (11) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;

        test_reset_values();
        test_register_readback();
        test_compare_zero();
        test_postscaler_period();
        test_unused_prescale_codes();
        test_random_traffic();

        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
